// ----- design/kms_pkg.sv -----
// Keypad matrix scanner package: geometry, widths and shared types.
// Used by the keypad scanner modules other than kms_ram; depends on nothing.
package kms_pkg;

    localparam int NUM_COLUMNS = 3;
    localparam int NUM_ROWS    = 4;
    localparam int QUEUE_DEPTH = 64;

    localparam int COL_W    = $clog2(NUM_COLUMNS);
    localparam int KEY_W    = 4;
    localparam int SETTLE_W = 16;
    localparam int EVT_W    = KEY_W + 1;
    localparam int PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int OFF_W    = $clog2(NUM_ROWS + 1);

    localparam int BANK_BITS  = $clog2(NUM_ROWS);
    localparam int NUM_BANKS  = 1 << BANK_BITS;
    localparam int BANK_DEPTH = QUEUE_DEPTH / NUM_BANKS;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(120);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 2'd1;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef struct packed {
        logic                take;
        logic [COL_W-1:0]    col;
        logic [NUM_ROWS-1:0] changed;
        logic [NUM_ROWS-1:0] levels;
    } t_sample;

endpackage

// ----- design/kms_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/kms_scan.sv -----
// Column scan sequencer and stored key levels; emits the changed-row sample.
// Depends on kms_pkg.
module kms_scan (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_tick,
    input  logic [kms_pkg::NUM_ROWS-1:0]    i_rows,
    input  logic                            i_scan_enable,
    input  logic [kms_pkg::SETTLE_W-1:0]    i_settle_ticks,
    output kms_pkg::t_sample                o_sample,
    output logic [kms_pkg::NUM_COLUMNS-1:0] o_drive
);

    logic [kms_pkg::COL_W-1:0]    r_col,   n_col;
    logic                         r_phase, n_phase;
    logic [kms_pkg::SETTLE_W-1:0] r_count, n_count;
    logic [kms_pkg::NUM_ROWS-1:0] r_levels [kms_pkg::NUM_COLUMNS];

    logic [kms_pkg::SETTLE_W-1:0] limit;
    logic [kms_pkg::SETTLE_W:0]   count_inc;
    logic [kms_pkg::COL_W:0]      col_inc;
    logic                         phase_end;
    logic                         take;

    always_comb begin
        limit     = (i_settle_ticks == '0) ? kms_pkg::SETTLE_W'(1) : i_settle_ticks;
        count_inc = {1'b0, r_count} + 1'b1;
        col_inc   = {1'b0, r_col} + 1'b1;
        phase_end = (count_inc >= {1'b0, limit});
        take      = i_tick && i_scan_enable && phase_end && !r_phase;

        n_col   = r_col;
        n_phase = r_phase;
        n_count = r_count;
        if (i_tick) begin
            if (!i_scan_enable) begin
                n_col   = '0;
                n_phase = 1'b0;
                n_count = '0;
            end else if (phase_end) begin
                n_count = '0;
                if (!r_phase) begin
                    n_phase = 1'b1;
                end else begin
                    n_phase = 1'b0;
                    n_col   = (col_inc >= (kms_pkg::COL_W+1)'(kms_pkg::NUM_COLUMNS)) ?
                              '0 : col_inc[kms_pkg::COL_W-1:0];
                end
            end else begin
                n_count = count_inc[kms_pkg::SETTLE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_phase <= 1'b0;
            r_count <= '0;
            for (int c = 0; c < kms_pkg::NUM_COLUMNS; c++) begin
                r_levels[c] <= '0;
            end
        end else begin
            r_col   <= n_col;
            r_phase <= n_phase;
            r_count <= n_count;
            if (take) begin
                r_levels[r_col] <= i_rows;
            end
        end
    end

    always_comb begin
        o_sample.take    = take;
        o_sample.col     = r_col;
        o_sample.levels  = i_rows;
        o_sample.changed = take ? (i_rows ^ r_levels[r_col]) : '0;
    end

    assign o_drive = (i_scan_enable && !r_phase) ?
                     (kms_pkg::NUM_COLUMNS'(1) << r_col) : '0;

endmodule

// ----- design/kms_queue.sv -----
// Banked event FIFO: up to NUM_ROWS pushes per item, one pop, sticky overflow.
// Depends on kms_pkg and kms_ram.
module kms_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  kms_pkg::t_sample             i_sample,
    input  logic                         i_pop,
    output logic [kms_pkg::CNT_W-1:0]    o_count,
    output logic                         o_overflow,
    output logic [kms_pkg::KEY_W-1:0]    o_key,
    output logic                         o_level
);

    localparam int NB = kms_pkg::NUM_BANKS;
    localparam int NR = kms_pkg::NUM_ROWS;

    logic [kms_pkg::PTR_W-1:0]     r_head, r_tail, n_head, n_tail;
    logic [kms_pkg::CNT_W-1:0]     r_count, n_count;
    logic                          r_overflow;
    logic [kms_pkg::BANK_BITS-1:0] r_rd_bank;

    logic [kms_pkg::OFF_W-1:0]     off [NR];
    logic [NR-1:0]                 acc;
    logic [kms_pkg::PTR_W-1:0]     slot [NR];
    logic [kms_pkg::PTR_W:0]       slot_sum [NR];
    logic [kms_pkg::CNT_W-1:0]     free_cnt;
    logic [kms_pkg::OFF_W-1:0]     npush;
    logic                          drop;
    logic [kms_pkg::PTR_W:0]       tail_sum, head_sum;
    logic [kms_pkg::KEY_W-1:0]     row_key [NR];

    logic [NB-1:0]                 we;
    logic [kms_pkg::BANK_AW-1:0]   waddr [NB];
    logic [kms_pkg::EVT_W-1:0]     wdata [NB];
    logic [NB-1:0]                 re;
    logic [kms_pkg::EVT_W-1:0]     rdata [NB];

    always_comb begin
        free_cnt = kms_pkg::CNT_W'(kms_pkg::QUEUE_DEPTH) - r_count;
        npush    = '0;
        drop     = 1'b0;
        for (int r = 0; r < NR; r++) begin
            off[r]      = npush;
            acc[r]      = i_sample.changed[r] &&
                          (kms_pkg::CNT_W'(npush) < free_cnt);
            drop        = drop || (i_sample.changed[r] && !acc[r]);
            npush       = npush + kms_pkg::OFF_W'(acc[r]);
            slot_sum[r] = {1'b0, r_tail} + (kms_pkg::PTR_W+1)'(off[r]);
            slot[r]     = (slot_sum[r] >= (kms_pkg::PTR_W+1)'(kms_pkg::QUEUE_DEPTH)) ?
                          kms_pkg::PTR_W'(slot_sum[r] -
                                          (kms_pkg::PTR_W+1)'(kms_pkg::QUEUE_DEPTH)) :
                          slot_sum[r][kms_pkg::PTR_W-1:0];
            row_key[r]  = kms_pkg::KEY_W'(int'(i_sample.col) * NR + r);
        end

        for (int b = 0; b < NB; b++) begin
            we[b]    = 1'b0;
            waddr[b] = '0;
            wdata[b] = '0;
            for (int r = 0; r < NR; r++) begin
                if (acc[r] && (slot[r][kms_pkg::BANK_BITS-1:0] ==
                               kms_pkg::BANK_BITS'(b))) begin
                    we[b]    = 1'b1;
                    waddr[b] = slot[r][kms_pkg::PTR_W-1:kms_pkg::BANK_BITS];
                    wdata[b] = {row_key[r], i_sample.levels[r]};
                end
            end
            re[b] = i_pop && (r_head[kms_pkg::BANK_BITS-1:0] == kms_pkg::BANK_BITS'(b));
        end

        tail_sum = {1'b0, r_tail} + (kms_pkg::PTR_W+1)'(npush);
        n_tail   = (tail_sum >= (kms_pkg::PTR_W+1)'(kms_pkg::QUEUE_DEPTH)) ?
                   kms_pkg::PTR_W'(tail_sum - (kms_pkg::PTR_W+1)'(kms_pkg::QUEUE_DEPTH)) :
                   tail_sum[kms_pkg::PTR_W-1:0];
        head_sum = {1'b0, r_head} + 1'b1;
        n_head   = r_head;
        if (i_pop) begin
            n_head = (head_sum >= (kms_pkg::PTR_W+1)'(kms_pkg::QUEUE_DEPTH)) ?
                     '0 : head_sum[kms_pkg::PTR_W-1:0];
        end
        n_count = r_count + kms_pkg::CNT_W'(npush) - kms_pkg::CNT_W'(i_pop);
    end

    for (genvar b = 0; b < NB; b++) begin : g_bank
        kms_ram #(
            .WIDTH (kms_pkg::EVT_W),
            .DEPTH (kms_pkg::BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we[b]),
            .i_waddr (waddr[b]),
            .i_wdata (wdata[b]),
            .i_re    (re[b]),
            .i_raddr (r_head[kms_pkg::PTR_W-1:kms_pkg::BANK_BITS]),
            .o_rdata (rdata[b])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_rd_bank  <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            if (drop) begin
                r_overflow <= 1'b1;
            end
            if (i_pop) begin
                r_rd_bank <= r_head[kms_pkg::BANK_BITS-1:0];
            end
        end
    end

    assign o_count    = r_count;
    assign o_overflow = r_overflow;
    assign o_key      = rdata[r_rd_bank][kms_pkg::EVT_W-1:1];
    assign o_level    = rdata[r_rd_bank][0];

endmodule

// ----- design/keypad_matrix_scanner.sv -----
// Keypad matrix scanner top: stream ports, configuration registers, result stage.
// Depends on kms_pkg, kms_scan, kms_queue (and kms_ram through kms_queue).
//
//  channel   | direction | accept when                   | payload
//  ----------+-----------+-------------------------------+---------------------------
//  s_axis    | in        | s_axis_tvalid & s_axis_tready | tuser: func, tdata: rows
//  m_axis    | out       | m_axis_tvalid & m_axis_tready | tdata: result fields
//  cfg       | in        | i_cfg_valid & o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One item per clock; the result is shown the cycle after acceptance, held
// in the state and RAM read registers. Input ready drops only while a result
// waits and m_axis_tready is low. Synchronous active-low reset clears scan
// state, key levels and queue pointers; no clearing pass.
module keypad_matrix_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] row_levels, [7:4] zero
    input  logic        s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [2:0] column_drive, [3] event_valid,
                                        // [7:4] key_index, [8] key_level,
                                        // [15:9] queue_count, [16] overflow, rest 0
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [kms_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic                         r_scan_enable;
    logic [kms_pkg::SETTLE_W-1:0] r_settle_ticks;
    logic                         r_out_valid;
    logic                         r_evt_valid;

    logic                            in_accept;
    logic                            tick;
    logic                            pop;
    kms_pkg::t_sample                sample;
    logic [kms_pkg::NUM_COLUMNS-1:0] drive;
    logic [kms_pkg::CNT_W-1:0]       count;
    logic                            overflow;
    logic [kms_pkg::KEY_W-1:0]       key;
    logic                            level;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign tick          = in_accept && (s_axis_tuser == kms_pkg::FUNC_TICK);
    assign pop           = in_accept && (s_axis_tuser == kms_pkg::FUNC_POP) && (count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_enable  <= 1'b0;
            r_settle_ticks <= kms_pkg::SETTLE_RESET;
            r_out_valid    <= 1'b0;
            r_evt_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    kms_pkg::CFG_SCAN_ENABLE:  r_scan_enable  <= i_cfg_data[0];
                    kms_pkg::CFG_SETTLE_TICKS: r_settle_ticks <= i_cfg_data[kms_pkg::SETTLE_W-1:0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
                r_evt_valid <= pop;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    kms_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick         (tick),
        .i_rows         (s_axis_tdata[kms_pkg::NUM_ROWS-1:0]),
        .i_scan_enable  (r_scan_enable),
        .i_settle_ticks (r_settle_ticks),
        .o_sample       (sample),
        .o_drive        (drive)
    );

    kms_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (sample),
        .i_pop      (pop),
        .o_count    (count),
        .o_overflow (overflow),
        .o_key      (key),
        .o_level    (level)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0,
                            overflow,
                            count,
                            r_evt_valid ? level : 1'b0,
                            r_evt_valid ? key : {kms_pkg::KEY_W{1'b0}},
                            r_evt_valid,
                            drive};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= kms_pkg::CNT_W'(kms_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_pop_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (count == $past(count) - 1'b1))
        else $error("pop did not decrement count");

    a_overflow_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        overflow |=> overflow)
        else $error("overflow flag cleared");

    a_drive_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(drive) && (!r_scan_enable -> drive == '0))
        else $error("bad column drive");
`endif

endmodule

// ----- bench/tb_keypad_matrix_scanner.sv -----
// Self-checking bench for keypad_matrix_scanner: stream items in, one key report out per item.
// An in-bench scanner predictor checks every report; depends on kms_pkg and the design sources.
// Directed reset, scan and config corners, random scan phases, then a fill to queue overflow.
module tb_keypad_matrix_scanner;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       overflow;
        logic [6:0] queue_count;
        logic       key_level;
        logic [3:0] key_index;
        logic       event_valid;
        logic [2:0] column_drive;
    } t_key_report;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata  = '0;
    logic                          s_axis_tuser  = kms_pkg::FUNC_TICK;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [23:0]                   m_axis_tdata;
    logic                          i_cfg_valid   = 1'b0;
    logic                          o_cfg_ready;
    logic [kms_pkg::CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [31:0]                   i_cfg_data    = '0;

    keypad_matrix_scanner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // scanner shadow state
    logic                 cfg_scan_en = 1'b0;
    logic [15:0]          cfg_settle  = kms_pkg::SETTLE_RESET;
    int                   scan_col    = 0;
    logic                 scan_low    = 1'b0;
    logic [15:0]          settle_cnt  = '0;
    logic [kms_pkg::NUM_COLUMNS*kms_pkg::NUM_ROWS-1:0] key_state = '0;
    logic [4:0]           key_events[$];
    logic                 ovf_sticky  = 1'b0;

    t_key_report reports_due[$];

    int   n_errors   = 0;
    int   n_items    = 0;
    int   n_checked  = 0;
    int   n_popped   = 0;
    int   n_cfg      = 0;
    int   stall_left = 0;
    bit   idle_on    = 1'b0;
    bit   item_held  = 1'b0;
    bit   ovf_seen   = 1'b0;

    function automatic t_key_report step_scanner(input logic func, input logic [3:0] rows);
        t_key_report r;
        int          lim;
        int          key;
        logic [4:0]  ev;
        r = '0;
        if (func == kms_pkg::FUNC_TICK) begin
            lim = (cfg_settle == 16'd0) ? 1 : int'(cfg_settle);
            if (!cfg_scan_en) begin
                scan_col   = 0;
                scan_low   = 1'b0;
                settle_cnt = '0;
            end else if (int'(settle_cnt) + 1 >= lim) begin
                settle_cnt = '0;
                if (!scan_low) begin
                    for (int k = 0; k < kms_pkg::NUM_ROWS; k++) begin
                        key = k + scan_col * kms_pkg::NUM_ROWS;
                        if (key < kms_pkg::NUM_COLUMNS * kms_pkg::NUM_ROWS &&
                            key_state[key] != rows[k]) begin
                            key_state[key] = rows[k];
                            if (key_events.size() >= kms_pkg::QUEUE_DEPTH)
                                ovf_sticky = 1'b1;
                            else
                                key_events.push_back({4'(key), rows[k]});
                        end
                    end
                    scan_low = 1'b1;
                end else begin
                    scan_low = 1'b0;
                    scan_col = (scan_col + 1 >= kms_pkg::NUM_COLUMNS) ? 0 : scan_col + 1;
                end
            end else begin
                settle_cnt = settle_cnt + 16'd1;
            end
        end else if (key_events.size() > 0) begin
            ev            = key_events.pop_front();
            r.event_valid = 1'b1;
            r.key_index   = ev[4:1];
            r.key_level   = ev[0];
        end
        r.column_drive = (cfg_scan_en && !scan_low) ? 3'(1 << scan_col) : 3'd0;
        r.queue_count  = 7'(key_events.size());
        r.overflow     = ovf_sticky;
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input int got, input int want);
        if (n_errors < 40)
            $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
        n_errors++;
    endtask

    always @(posedge i_clk) begin : check_reports
        t_key_report got;
        t_key_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_key_report'(m_axis_tdata[16:0]);
            if (reports_due.size() == 0) begin
                flag_mismatch("unexpected report", int'(got), 0);
            end else begin
                want = reports_due.pop_front();
                n_checked++;
                if (got.event_valid)
                    n_popped++;
                if (got.column_drive !== want.column_drive)
                    flag_mismatch("column_drive", got.column_drive, want.column_drive);
                if (got.event_valid !== want.event_valid)
                    flag_mismatch("event_valid", got.event_valid, want.event_valid);
                if (got.key_index !== want.key_index)
                    flag_mismatch("key_index", got.key_index, want.key_index);
                if (got.key_level !== want.key_level)
                    flag_mismatch("key_level", got.key_level, want.key_level);
                if (got.queue_count !== want.queue_count)
                    flag_mismatch("queue_count", got.queue_count, want.queue_count);
                if (got.overflow !== want.overflow)
                    flag_mismatch("overflow", got.overflow, want.overflow);
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic drop_valid();
        if (item_held) begin
            s_axis_tvalid <= 1'b0;
            item_held = 1'b0;
        end
    endtask

    task automatic send_item(input logic func, input logic [3:0] rows);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            drop_valid();
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {4'b0000, rows};
        item_held = 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        n_items++;
        reports_due.push_back(step_scanner(func, rows));
        if (ovf_sticky)
            ovf_seen = 1'b1;
    endtask

    task automatic hold_until_drained();
        drop_valid();
        while (reports_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [kms_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        hold_until_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        case (idx)
            kms_pkg::CFG_SCAN_ENABLE:  cfg_scan_en = data[0];
            kms_pkg::CFG_SETTLE_TICKS: cfg_settle  = data[15:0];
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic test_reset_state();
        send_item(kms_pkg::FUNC_POP, 4'hF);
        send_item(kms_pkg::FUNC_TICK, 4'hF);
        send_item(kms_pkg::FUNC_TICK, 4'h0);
    endtask

    task automatic test_scan_basic();
        cfg_write(kms_pkg::CFG_SETTLE_TICKS, {16'($urandom()), 16'd1});
        cfg_write(kms_pkg::CFG_SCAN_ENABLE, {31'($urandom()), 1'b1});
        repeat (6) send_item(kms_pkg::FUNC_TICK, 4'hF);
        repeat (2) send_item(kms_pkg::FUNC_TICK, 4'h0);
        repeat (3) send_item(kms_pkg::FUNC_POP, 4'(($urandom())));
    endtask

    task automatic test_config_corners();
        cfg_write(2'd2, $urandom());
        cfg_write(2'd3, $urandom());
        cfg_write(kms_pkg::CFG_SETTLE_TICKS, {16'($urandom()), 16'd0});
        repeat (3) send_item(kms_pkg::FUNC_TICK, 4'b1010);
        cfg_write(kms_pkg::CFG_SETTLE_TICKS, {16'($urandom()), 16'hFFFF});
        repeat (3) send_item(kms_pkg::FUNC_TICK, 4'b0101);
        cfg_write(kms_pkg::CFG_SCAN_ENABLE, {31'($urandom()), 1'b0});
        send_item(kms_pkg::FUNC_TICK, 4'hF);
    endtask

    task automatic test_random_scan();
        int          sel;
        int          pop_pct;
        logic [15:0] st;
        for (int ph = 0; ph < 10; ph++) begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                st = 16'd0;
            else if (sel == 1 && ph > 5)
                st = 16'hFFFF;
            else if (sel < 4)
                st = 16'($urandom_range(5, 12));
            else
                st = 16'($urandom_range(1, 4));
            cfg_write(kms_pkg::CFG_SETTLE_TICKS, {16'($urandom()), st});
            cfg_write(kms_pkg::CFG_SCAN_ENABLE, {31'($urandom()), 1'(ph % 4 != 3)});
            idle_on = (ph % 3 != 2);
            pop_pct = $urandom_range(15, 60);
            for (int k = 0; k < 110; k++) begin
                if (ph == 4 && k == 55)
                    hold_until_drained();
                if ($urandom_range(1, 100) <= pop_pct)
                    send_item(kms_pkg::FUNC_POP, 4'($urandom()));
                else
                    send_item(kms_pkg::FUNC_TICK, 4'($urandom()));
            end
        end
    endtask

    task automatic test_queue_overflow();
        int guard;
        idle_on = 1'b0;
        cfg_write(kms_pkg::CFG_SETTLE_TICKS, {16'($urandom()), 16'd1});
        cfg_write(kms_pkg::CFG_SCAN_ENABLE, {31'($urandom()), 1'b1});
        guard = 0;
        while (!ovf_sticky && guard < 600) begin
            send_item(kms_pkg::FUNC_TICK, 4'($urandom()));
            guard++;
        end
        repeat (10) send_item(kms_pkg::FUNC_TICK, 4'($urandom()));
        while (key_events.size() > 0)
            send_item(kms_pkg::FUNC_POP, 4'($urandom()));
        repeat (2) send_item(kms_pkg::FUNC_POP, 4'($urandom()));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_scan_basic();
        test_config_corners();
        test_random_scan();
        test_queue_overflow();
        hold_until_drained();
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d items, %0d reports checked, %0d key events popped,",
                 n_items, n_checked, n_popped);
        $display("%0d register writes, queue overflow reached: %0d", n_cfg, ovf_seen);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d reports outstanding", reports_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
design/kms_pkg.sv
design/kms_ram.sv
design/kms_scan.sv
design/kms_queue.sv
design/keypad_matrix_scanner.sv
bench/tb_keypad_matrix_scanner.sv
